[rtl/fmpm_pkg.sv]
// ============================================================================
// fmpm_pkg
// shared types, constants and the arctangent table of the fm phase modulator
// ============================================================================
package fmpm_pkg;

    // default parameter values
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int PHASE_BITS_DEF  = 32;

    // register and field widths fixed by the interface
    localparam int GAIN_W    = 16;
    localparam int DEV_W     = 33;
    localparam int DEV_LO_W  = 17;
    localparam int DEV_HI_W  = DEV_W - DEV_LO_W;
    localparam int OUT_W     = 16;
    localparam int CFG_ADDR_W = 2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_AUDIO_GAIN      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_DEVIATION = 2'd1;

    // register reset values: gain 0.8 in q2.14, 2.5 khz deviation at 48 khz
    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd13107;
    localparam logic [DEV_W-1:0]  DEV_RST  = 33'd223696213;

    // amplitude after gain has 29 fraction bits, clipped to +/- 1.0
    localparam int AMP_FRAC = 29;
    localparam int AMP_W    = AMP_FRAC + 2;
    localparam int AMP_LIM  = 1 << AMP_FRAC;

    // cordic
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_X0    = 652032874;
    localparam int ATAN_W       = 30;
    localparam int THETA_W      = 32;
    localparam int ROUND_HALF   = 16384;
    localparam int Q15_SHIFT    = 15;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLIP,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_STEP,
        ST_ACC,
        ST_INIT,
        ST_ROT,
        ST_OUT
    } fmpm_state_t;

    typedef struct packed {
        logic ld_prod;
        logic ld_amp;
        logic ld_pp_lo;
        logic ld_pp_hi;
        logic ld_step;
        logic ld_acc;
        logic ld_init;
        logic rot;
        logic ld_out;
    } fmpm_cmd_t;

    typedef struct packed {
        logic rot_last;
    } fmpm_sts_t;

    // atan(2^-i) in units of 2pi/2^32
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [ITER_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            4'd0:    v = 30'h20000000;
            4'd1:    v = 30'h12E4051E;
            4'd2:    v = 30'h09FB385B;
            4'd3:    v = 30'h051111D4;
            4'd4:    v = 30'h028B0D43;
            4'd5:    v = 30'h0145D7E1;
            4'd6:    v = 30'h00A2F61E;
            4'd7:    v = 30'h00517C55;
            4'd8:    v = 30'h0028BE53;
            4'd9:    v = 30'h00145F2F;
            4'd10:   v = 30'h000A2F98;
            4'd11:   v = 30'h000517CC;
            4'd12:   v = 30'h00028BE6;
            4'd13:   v = 30'h000145F3;
            4'd14:   v = 30'h0000A2FA;
            default: v = 30'h0000517D;
        endcase
        return v;
    endfunction

endpackage

[rtl/fmpm_regs.sv]
// ============================================================================
// fmpm_regs
// configuration registers: microphone gain and phase deviation
// ============================================================================
module fmpm_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fmpm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [fmpm_pkg::DEV_W-1:0]        cfg_wdata,
    output logic [fmpm_pkg::GAIN_W-1:0]       audio_gain,
    output logic [fmpm_pkg::DEV_W-1:0]        phase_deviation
);
    import fmpm_pkg::*;

    logic [GAIN_W-1:0] gain_reg;
    logic [DEV_W-1:0]  dev_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RST;
            dev_reg  <= DEV_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_AUDIO_GAIN:      gain_reg <= cfg_wdata[GAIN_W-1:0];
                REG_PHASE_DEVIATION: dev_reg  <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    assign audio_gain      = gain_reg;
    assign phase_deviation = dev_reg;

endmodule

[rtl/fmpm_ctrl.sv]
// ============================================================================
// fmpm_ctrl
// sequencer: gain, clip, two partial products, phase update, cordic, output
// ============================================================================
module fmpm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output fmpm_pkg::fmpm_cmd_t   cmd,
    input  fmpm_pkg::fmpm_sts_t   sts
);
    import fmpm_pkg::*;

    fmpm_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_CLIP;
            ST_CLIP:   state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_STEP;
            ST_STEP:   state_next = ST_ACC;
            ST_ACC:    state_next = ST_INIT;
            ST_INIT:   state_next = ST_ROT;
            ST_ROT:    if (sts.rot_last) state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.ld_prod = s_valid;
            end
            ST_CLIP:   cmd.ld_amp   = 1'b1;
            ST_MUL_LO: cmd.ld_pp_lo = 1'b1;
            ST_MUL_HI: cmd.ld_pp_hi = 1'b1;
            ST_STEP:   cmd.ld_step  = 1'b1;
            ST_ACC:    cmd.ld_acc   = 1'b1;
            ST_INIT:   cmd.ld_init  = 1'b1;
            ST_ROT:    cmd.rot      = 1'b1;
            ST_OUT:    cmd.ld_out   = out_free;
            default:   ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.ld_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

[rtl/fmpm_datapath.sv]
// ============================================================================
// fmpm_datapath
// gain multiply and clip, deviation scaling, phase accumulator, cordic
// ============================================================================
module fmpm_datapath #(
    parameter int SAMPLE_BITS = fmpm_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS  = fmpm_pkg::PHASE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fmpm_pkg::fmpm_cmd_t                 cmd,
    output fmpm_pkg::fmpm_sts_t                 sts,
    input  logic signed [SAMPLE_BITS-1:0]       audio_sample,
    input  logic [fmpm_pkg::GAIN_W-1:0]         audio_gain,
    input  logic [fmpm_pkg::DEV_W-1:0]          phase_deviation,
    output logic signed [fmpm_pkg::OUT_W-1:0]   i_out,
    output logic signed [fmpm_pkg::OUT_W-1:0]   q_out
);
    import fmpm_pkg::*;

    localparam int PROD_W  = SAMPLE_BITS + GAIN_W + 1;
    localparam int NORM_W  = (PROD_W > 33) ? PROD_W : 33;
    localparam int PPLO_W  = AMP_W + DEV_LO_W + 1;
    localparam int PPHI_W  = AMP_W + DEV_HI_W + 1;
    localparam int SUM_W   = AMP_W + DEV_W + 1;
    localparam int STEP_W  = SUM_W - AMP_FRAC;
    localparam int SX_W    = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;
    localparam int CW      = CORDIC_W;
    localparam int RW      = CW + 2;

    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [NORM_W-1:0]  norm;
    logic signed [AMP_W-1:0]   amp_reg, amp_next;
    logic signed [PPLO_W-1:0]  pp_lo_reg;
    logic signed [PPHI_W-1:0]  pp_hi_reg;
    logic signed [SUM_W-1:0]   pp_sum;
    logic signed [STEP_W-1:0]  step_reg;
    logic signed [SX_W-1:0]    step_ext;
    logic [PHASE_BITS-1:0]     phase_acc_reg;
    logic [THETA_W-1:0]        theta;
    logic signed [CW-1:0]      x_reg, y_reg, z_reg;
    logic signed [CW-1:0]      dx, dy, at;
    logic [1:0]                quad_reg;
    logic [ITER_W-1:0]         iter_reg;
    logic signed [CW:0]        sn, cs;
    logic signed [OUT_W-1:0]   i_out_reg, q_out_reg;

    // q.30 to q1.15 with round half up and saturation
    function automatic logic signed [OUT_W-1:0] to_q15(input logic signed [CW:0] v);
        logic signed [RW-1:0]           t;
        logic signed [RW-Q15_SHIFT-1:0] r;
        logic signed [OUT_W-1:0]        res;
        t = RW'(v) + RW'(ROUND_HALF);
        r = t[RW-1:Q15_SHIFT];
        if (r > (RW-Q15_SHIFT)'(32767)) begin
            res = 16'sd32767;
        end else if (r < -(RW-Q15_SHIFT)'(32768)) begin
            res = -16'sd32768;
        end else begin
            res = r[OUT_W-1:0];
        end
        return res;
    endfunction

    // bring the product to 29 fraction bits
    generate
        if (SAMPLE_BITS > 16) begin : g_norm_dn
            assign norm = prod_reg >>> (SAMPLE_BITS - 16);
        end else if (SAMPLE_BITS == 16) begin : g_norm_eq
            assign norm = prod_reg;
        end else begin : g_norm_up
            assign norm = NORM_W'(prod_reg) <<< (16 - SAMPLE_BITS);
        end
    endgenerate

    always_comb begin
        if (norm > NORM_W'(AMP_LIM)) begin
            amp_next = AMP_W'(AMP_LIM);
        end else if (norm < -NORM_W'(AMP_LIM)) begin
            amp_next = -AMP_W'(AMP_LIM);
        end else begin
            amp_next = norm[AMP_W-1:0];
        end
    end

    assign pp_sum   = SUM_W'(pp_lo_reg) + (SUM_W'(pp_hi_reg) <<< DEV_LO_W);
    assign step_ext = SX_W'(step_reg);

    generate
        if (PHASE_BITS >= THETA_W) begin : g_theta_top
            assign theta = phase_acc_reg[PHASE_BITS-1 -: THETA_W];
        end else begin : g_theta_pad
            assign theta = {phase_acc_reg, {(THETA_W-PHASE_BITS){1'b0}}};
        end
    endgenerate

    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;
    assign at = $signed({{(CW-ATAN_W){1'b0}}, atan_lut(iter_reg)});

    // quadrant fold
    always_comb begin
        case (quad_reg)
            2'd0: begin
                sn = (CW+1)'(y_reg);
                cs = (CW+1)'(x_reg);
            end
            2'd1: begin
                sn = (CW+1)'(x_reg);
                cs = -(CW+1)'(y_reg);
            end
            2'd2: begin
                sn = -(CW+1)'(y_reg);
                cs = -(CW+1)'(x_reg);
            end
            default: begin
                sn = -(CW+1)'(x_reg);
                cs = (CW+1)'(y_reg);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg <= '0;
        end else if (cmd.ld_acc) begin
            phase_acc_reg <= phase_acc_reg + step_ext[PHASE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_prod) begin
            prod_reg <= audio_sample * $signed({1'b0, audio_gain});
        end
        if (cmd.ld_amp) begin
            amp_reg <= amp_next;
        end
        if (cmd.ld_pp_lo) begin
            pp_lo_reg <= amp_reg * $signed({1'b0, phase_deviation[DEV_LO_W-1:0]});
        end
        if (cmd.ld_pp_hi) begin
            pp_hi_reg <= amp_reg * $signed({1'b0, phase_deviation[DEV_W-1:DEV_LO_W]});
        end
        if (cmd.ld_step) begin
            step_reg <= pp_sum[SUM_W-1:AMP_FRAC];
        end
        if (cmd.ld_init) begin
            x_reg    <= CW'(CORDIC_X0);
            y_reg    <= '0;
            z_reg    <= $signed({{(CW-30){1'b0}}, theta[29:0]});
            quad_reg <= theta[31:30];
            iter_reg <= '0;
        end else if (cmd.rot) begin
            if (!z_reg[CW-1]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
            iter_reg <= iter_reg + 1'b1;
        end
        if (cmd.ld_out) begin
            i_out_reg <= to_q15(sn);
            q_out_reg <= to_q15(cs);
        end
    end

    assign sts.rot_last = (iter_reg == ITER_W'(CORDIC_STEPS - 1));
    assign i_out        = i_out_reg;
    assign q_out        = q_out_reg;

endmodule

[rtl/fm_phase_modulator_core.sv]
// ============================================================================
// fm_phase_modulator_core
// fm modulator: audio gain and clip, deviation scaling, phase accumulator,
// iterative cordic producing i = sin(phase) and q = cos(phase) in q1.15
// ============================================================================
//
//  channel   ports                                     width       role
//  -------   ---------------------------------------   ---------   -----------------
//  input     s_valid s_ready s_audio_sample            SAMPLE_BITS audio, signed q1.x
//  result    m_valid m_ready m_i_out m_q_out           16 + 16     sin / cos, q1.15
//  config    cfg_wr_en cfg_addr cfg_wdata              2 / 33      0 gain, 1 deviation
//
//  one transaction at a time: the gain product is taken at the accepting edge
//  and the result is registered after these steps: clip, two deviation partial
//  products, step, phase add, cordic init, 16 cordic iterations, output load;
//  the iterative cordic does one step per cycle
//  s_ready is high only while idle; the next sample can be taken in the cycle
//  after the result is loaded, never before the previous one is finished
//  a finished result waits in the output register; if it is still held when
//  the next one completes, the sequencer holds in its output step
//  synchronous active-low reset clears the phase accumulator and loads the
//  register defaults (gain 0.8, narrowband deviation)
//
module fm_phase_modulator_core #(
    parameter int SAMPLE_BITS = fmpm_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS  = fmpm_pkg::PHASE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input transaction
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_audio_sample,
    // result transaction
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [fmpm_pkg::OUT_W-1:0]   m_i_out,
    output logic signed [fmpm_pkg::OUT_W-1:0]   m_q_out,
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [fmpm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [fmpm_pkg::DEV_W-1:0]          cfg_wdata
);
    import fmpm_pkg::*;

    // command and status between sequencer and datapath
    fmpm_cmd_t          cmd;
    fmpm_sts_t          sts;
    // live register values
    logic [GAIN_W-1:0]  audio_gain;
    logic [DEV_W-1:0]   phase_deviation;

    fmpm_regs u_regs (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .audio_gain      (audio_gain),
        .phase_deviation (phase_deviation)
    );

    // sequencer owns the handshakes and the output valid flag
    fmpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // datapath: sample is multiplied by the gain in the accept cycle
    fmpm_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .PHASE_BITS  (PHASE_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .audio_sample    (s_audio_sample),
        .audio_gain      (audio_gain),
        .phase_deviation (phase_deviation),
        .i_out           (m_i_out),
        .q_out           (m_q_out)
    );

`ifndef SYNTHESIS
    // s_ready drops after a sample is taken, so samples are never taken back to back
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a sample is in flight");

    // a new result is only loaded into a free output register
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_out |-> (!m_valid || m_ready))
        else $error("output register overwritten before it was taken");

    // result valid only rises after an output load
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.ld_out))
        else $error("result valid without an output load");

    // the phase accumulator only moves between an input and its result
    a_acc_and_rot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_acc |-> !s_ready && !cmd.rot)
        else $error("phase update outside the sample sequence");
`endif

endmodule
